[sv/hfe_pkg.sv]
// Shared types, constants and the CRC-16/X.25 byte update for the HDLC frame encoder.
// No dependencies; every other file of the block but hfe_if imports this package.
package hfe_pkg;

  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'h8408;
  localparam logic [7:0]  FLAG_BYTE = 8'h7E;
  localparam logic [7:0]  ESC_BYTE  = 8'h7D;
  localparam logic [7:0]  ESC_XOR   = 8'h20;

  // Queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  // One classified item: payload byte, end-of-frame mark and the finished trailer
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        frame_end;
    logic [15:0] crc_out;
  } hfe_entry_t;

  // Write side of the queue
  typedef struct packed {
    logic       valid;
    hfe_entry_t entry;
  } hfe_push_t;

  // Read side status of the queue
  typedef struct packed {
    logic       valid;
    hfe_entry_t entry;
  } hfe_head_t;

  // Fold one byte into the reflected CRC, LSB first
  function automatic logic [15:0] hfe_crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[sv/hfe_if.sv]
// Valid/ready channel interfaces for the HDLC frame encoder's input and output.
// Depends on nothing; payload widths are fixed by the field definitions.
interface hfe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_end;

  modport source (output valid, data_byte, frame_end, input ready);
  modport sink   (input valid, data_byte, frame_end, output ready);
endinterface

interface hfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       frame_done;

  modport source (output valid, out_byte, run_last, frame_done, input ready);
  modport sink   (input valid, out_byte, run_last, frame_done, output ready);
endinterface

[sv/hfe_front.sv]
// Front end: accepts payload beats, runs the frame CRC and pushes classified entries.
// Depends on hfe_pkg and hfe_in_if.
module hfe_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  hfe_in_if.sink          in_i,
  input  logic            q_full_i,
  output hfe_pkg::hfe_push_t push_o
);
  import hfe_pkg::*;

  logic [15:0] crc_q, crc_d;
  logic [15:0] crc_next;
  logic        accept;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && !q_full_i;
  assign crc_next   = hfe_crc_feed(crc_q, in_i.data_byte);

  // Restart the CRC after the last byte of a frame
  always_comb begin
    crc_d = crc_q;
    if (accept) begin
      crc_d = in_i.frame_end ? CRC_INIT : crc_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CRC_INIT;
    end else begin
      crc_q <= crc_d;
    end
  end

  // Build the queue entry with the inverted CRC ready for the trailer
  always_comb begin
    push_o.valid           = accept;
    push_o.entry.data_byte = in_i.data_byte;
    push_o.entry.frame_end = in_i.frame_end;
    push_o.entry.crc_out   = crc_next ^ CRC_INIT;
  end

  a_crc_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.frame_end) |=> (crc_q == CRC_INIT))
    else $error("CRC not restarted after frame end");

endmodule

[sv/hfe_fifo.sv]
// Short register queue that decouples the front end from the byte sequencer.
// Depends on hfe_pkg for the entry type and depth.
module hfe_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hfe_pkg::hfe_push_t push_i,
  input  logic               pop_i,
  output logic               full_o,
  output hfe_pkg::hfe_head_t head_o
);
  import hfe_pkg::*;

  hfe_entry_t       mem_q [QDEPTH];
  logic [QAW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCW-1:0]   count_q, count_d;

  assign full_o       = (count_q == QCW'(QDEPTH));
  assign head_o.valid = (count_q != '0);
  assign head_o.entry = mem_q[rd_ptr_q];

  // Track occupancy
  always_comb begin
    count_d = count_q;
    if (push_i.valid && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i.valid && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i.valid) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_ptr_q] <= push_i.entry;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.valid |-> (!full_o || pop_i))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_o.valid)
    else $error("pop from empty queue");

  a_ptr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with count");

endmodule

[sv/hfe_back.sv]
// Back end: escapes each queued byte; a final entry adds CRC trailer and closing flag.
// Depends on hfe_pkg, hfe_out_if; one registered beat per cycle unless out_o stalls.
module hfe_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hfe_pkg::hfe_head_t head_i,
  output logic               pop_o,
  hfe_out_if.source          out_o
);
  import hfe_pkg::*;

  localparam logic [1:0] PH_DATA = 2'd0;
  localparam logic [1:0] PH_CRCL = 2'd1;
  localparam logic [1:0] PH_CRCH = 2'd2;
  localparam logic [1:0] PH_FLAG = 2'd3;

  logic [1:0] phase_q, phase_d;
  logic       esc_q, esc_d;
  logic [7:0] cur_byte, emit_byte;
  logic       needs_esc, fire, item_done;

  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       run_last_q, frame_done_q;

  assign fire = head_i.valid && (!out_valid_q || out_o.ready);

  // Pick the byte of the current phase
  always_comb begin
    case (phase_q)
      PH_DATA: cur_byte = head_i.entry.data_byte;
      PH_CRCL: cur_byte = head_i.entry.crc_out[7:0];
      PH_CRCH: cur_byte = head_i.entry.crc_out[15:8];
      default: cur_byte = FLAG_BYTE;
    endcase
    needs_esc = (phase_q != PH_FLAG) && (cur_byte inside {FLAG_BYTE, ESC_BYTE});
  end

  // Sequence escape, byte and next phase
  always_comb begin
    phase_d   = phase_q;
    esc_d     = esc_q;
    item_done = 1'b0;
    if (needs_esc && !esc_q) begin
      emit_byte = ESC_BYTE;
      esc_d     = 1'b1;
    end else begin
      emit_byte = esc_q ? (cur_byte ^ ESC_XOR) : cur_byte;
      esc_d     = 1'b0;
      if (phase_q == PH_FLAG || (phase_q == PH_DATA && !head_i.entry.frame_end)) begin
        item_done = 1'b1;
        phase_d   = PH_DATA;
      end else begin
        phase_d = phase_q + 2'd1;
      end
    end
  end

  assign pop_o = fire && item_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_DATA;
      esc_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        phase_q     <= phase_d;
        esc_q       <= esc_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load the output beat
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_byte_q   <= emit_byte;
      run_last_q   <= item_done;
      frame_done_q <= (phase_q == PH_FLAG);
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.out_byte   = out_byte_q;
  assign out_o.run_last   = run_last_q;
  assign out_o.frame_done = frame_done_q;

  a_esc_has_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (esc_q || phase_q != PH_DATA) |-> head_i.valid)
    else $error("sequencer mid-item without a queued entry");

  a_tail_only_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_DATA) |-> head_i.entry.frame_end)
    else $error("trailer phase on a non-final byte");

  a_flag_closes_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && frame_done_q) |-> (run_last_q && out_byte_q == FLAG_BYTE))
    else $error("closing flag not marked as last beat");

endmodule

[sv/hfe_frame_encoder_top_note.sv]
// Output stream checker: catches raw flag bytes inside a frame and broken escape pairs.
// Depends on hfe_pkg; watches the encoder's output handshake without driving it.
module hfe_esc_check (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  logic       ready_i,
  input  logic [7:0] out_byte_i,
  input  logic       frame_done_i
);
  import hfe_pkg::*;

  logic prev_esc_q;

  // Remember whether the last delivered beat was an escape byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_esc_q <= 1'b0;
    end else if (valid_i && ready_i) begin
      prev_esc_q <= (out_byte_i == ESC_BYTE) && !frame_done_i && !prev_esc_q;
    end
  end

  a_flag_unescaped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && out_byte_i == FLAG_BYTE) |-> frame_done_i)
    else $error("raw flag byte inside a frame");

  a_done_is_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && frame_done_i) |-> (out_byte_i == FLAG_BYTE))
    else $error("frame done on a byte other than the closing flag");

  a_esc_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && prev_esc_q) |-> (out_byte_i == (FLAG_BYTE ^ ESC_XOR) ||
                                 out_byte_i == (ESC_BYTE ^ ESC_XOR)))
    else $error("escape not followed by an escaped byte");

endmodule

[sv/hdlc_frame_encoder.sv]
// HDLC frame encoder top level: front end, entry queue and output byte sequencer.
// Depends on hfe_pkg, hfe_if, hfe_front, hfe_fifo, hfe_back and hfe_esc_check.
//
// Payload bytes enter on in_i, one per beat, with frame_end on the last byte of a frame.
// Each byte costs one output beat, two when it is 0x7E or 0x7D (sent as 0x7D, byte ^ 0x20);
// a final byte adds the inverted CRC-16/X.25 low byte first (escaped the same way) and a
// closing 0x7E, so one input beat yields 1 to 7 output beats. No opening flag is sent.
// Throughput is one output beat per cycle while out_o is ready, set by the back-end sequencer;
// with no escapes and no frame tails an input beat is taken every such cycle. A 4-entry queue lets
// the input keep running while a trailer drains; output beats leave from a register.
module hdlc_frame_encoder (
  input  logic      clk_i,
  input  logic      rst_ni,
  hfe_in_if.sink    in_i,
  hfe_out_if.source out_o
);
  import hfe_pkg::*;

  hfe_push_t push;
  hfe_head_t head;
  logic      q_full;
  logic      pop;

  hfe_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (push)
  );

  hfe_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .full_o (q_full),
    .head_o (head)
  );

  hfe_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

  // Watch the output stream for framing rule breaks
  hfe_esc_check u_esc_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (out_o.valid),
    .ready_i      (out_o.ready),
    .out_byte_i   (out_o.out_byte),
    .frame_done_i (out_o.frame_done)
  );

endmodule

[tb/hdlc_frame_encoder_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for hdlc_frame_encoder: directed table, then random frames.
// Depends on hfe_pkg, hfe_if and the encoder RTL; a local CRC-16/X.25 predictor checks every beat.
module hdlc_frame_encoder_tb;
  import hfe_pkg::*;

  localparam int unsigned NUM_ROWS    = 20;
  localparam int unsigned NUM_ITEMS   = 410;
  localparam int unsigned LONG_HOLD   = 120;
  localparam int unsigned DRAIN_TAIL  = 8;
  localparam int unsigned CYCLE_LIMIT = 500000;

  // One encoded output beat
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_done;
  } enc_beat_t;

  // Directed row; n_lit > 0 means the output bytes are typed in lit, lowest byte first
  typedef struct packed {
    logic [7:0]  data;
    logic        fin;
    logic [2:0]  n_lit;
    logic [31:0] lit;
  } stim_row_t;

  logic clk;
  logic rst_n;

  hfe_in_if  in_bus ();
  hfe_out_if out_bus ();

  hdlc_frame_encoder dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  enc_beat_t   encoded_q [$];
  enc_beat_t   beat_run [$];
  logic [15:0] frame_crc;
  stim_row_t   plan [0:NUM_ROWS-1];
  int unsigned sent_items;
  int unsigned errors;
  int unsigned cycle_cnt;
  logic        hold_req;
  logic        steady_tx;

  // Output beat sampled at the falling edge, checked at the next rising edge
  logic        out_fire;
  enc_beat_t   out_seen;

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Reflected CRC-16 update, one bit at a time, LSB first
  function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = c;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ b[i];
      r  = r >> 1;
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  // Stage one byte, escaped when it is a flag or escape byte, unless it is the closing flag
  function automatic void stage_byte(input logic [7:0] b, input logic closing);
    if (closing) begin
      beat_run.push_back('{out_byte: b, run_last: 1'b0, frame_done: 1'b1});
    end else if (b == FLAG_BYTE || b == ESC_BYTE) begin
      beat_run.push_back('{out_byte: ESC_BYTE, run_last: 1'b0, frame_done: 1'b0});
      beat_run.push_back('{out_byte: b ^ ESC_XOR, run_last: 1'b0, frame_done: 1'b0});
    end else begin
      beat_run.push_back('{out_byte: b, run_last: 1'b0, frame_done: 1'b0});
    end
  endfunction

  // Advance the frame CRC and queue the beats one accepted input beat causes
  function automatic void encode_payload(input logic [7:0] d, input logic fin,
                                         input logic [2:0] n_lit, input logic [31:0] lit);
    logic [15:0] tail;
    frame_crc = crc16_step(frame_crc, d);
    stage_byte(d, 1'b0);
    if (fin) begin
      tail = frame_crc ^ CRC_INIT;
      stage_byte(tail[7:0], 1'b0);
      stage_byte(tail[15:8], 1'b0);
      stage_byte(FLAG_BYTE, 1'b1);
      frame_crc = CRC_INIT;
    end
    beat_run[beat_run.size() - 1].run_last = 1'b1;
    if (n_lit != 0) begin
      for (int i = 0; i < n_lit; i++) begin
        encoded_q.push_back('{out_byte: lit[8*i +: 8],
                              run_last: (i == n_lit - 1),
                              frame_done: fin && (i == n_lit - 1)});
      end
    end else begin
      foreach (beat_run[i]) encoded_q.push_back(beat_run[i]);
    end
    beat_run.delete();
  endfunction

  // Offer one input beat after a random gap and hold it until accepted
  task automatic send_beat(input logic [7:0] d, input logic fin,
                           input logic [2:0] n_lit, input logic [31:0] lit);
    int unsigned roll;
    int unsigned gap;
    logic        took;
    roll = $urandom_range(0, 99);
    if (steady_tx || roll < 60) begin
      gap = 0;
    end else if (roll < 92) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = $urandom_range(6, 20);
    end
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.data_byte <= d;
    in_bus.frame_end <= fin;
    do begin
      @(negedge clk);
      took = in_bus.ready;
      if (took) begin
        encode_payload(d, fin, n_lit, lit);
        sent_items++;
      end
      @(posedge clk);
    end while (!took);
  endtask

  // Receiver: random stalls, open stretches, and one long hold on request
  initial begin
    int unsigned roll;
    int unsigned len;
    out_bus.ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_bus.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
          out_bus.ready <= 1'b1;
          len = $urandom_range(1, 6);
        end else if (roll < 70) begin
          out_bus.ready <= 1'b1;
          len = $urandom_range(20, 60);
        end else if (roll < 95) begin
          out_bus.ready <= 1'b0;
          len = $urandom_range(1, 3);
        end else begin
          out_bus.ready <= 1'b0;
          len = $urandom_range(8, 25);
        end
        repeat (len) @(posedge clk);
      end
    end
  end

  // Sample output beats away from the rising edge
  always @(negedge clk) begin
    out_fire = rst_n && out_bus.valid && out_bus.ready;
    out_seen = '{out_byte: out_bus.out_byte, run_last: out_bus.run_last,
                 frame_done: out_bus.frame_done};
  end

  // Compare each output beat with the oldest expected one
  always @(posedge clk) begin
    enc_beat_t want;
    if (out_fire) begin
      if (encoded_q.size() == 0) begin
        $error("unexpected output beat: out_byte %h", out_seen.out_byte);
        errors++;
      end else begin
        want = encoded_q.pop_front();
        if (out_seen.out_byte !== want.out_byte) begin
          $error("out_byte: expected %h, got %h", want.out_byte, out_seen.out_byte);
          errors++;
        end
        if (out_seen.run_last !== want.run_last) begin
          $error("run_last: expected %b, got %b", want.run_last, out_seen.run_last);
          errors++;
        end
        if (out_seen.frame_done !== want.frame_done) begin
          $error("frame_done: expected %b, got %b", want.frame_done, out_seen.frame_done);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Reset, directed table, random frames, drain
  initial begin
    int unsigned frame_no;
    int unsigned frame_len;
    int unsigned roll;
    logic [7:0]  d;
    logic [7:0]  cand;
    logic [7:0]  base;
    logic [15:0] t;
    logic        found;
    logic        seek;

    rst_n            <= 1'b0;
    in_bus.valid     <= 1'b0;
    in_bus.data_byte <= 8'h00;
    in_bus.frame_end <= 1'b0;
    frame_crc  = CRC_INIT;
    sent_items = 0;
    errors     = 0;
    cycle_cnt  = 0;
    hold_req   = 1'b0;
    steady_tx  = 1'b0;

    // Extremes and escapes typed in; frame tails from the predictor;
    // the standard check string closes with its known CRC 0x906E
    plan = '{
      '{8'h00, 1'b0, 3'd1, 32'h0000_0000},
      '{8'hFF, 1'b0, 3'd1, 32'h0000_00FF},
      '{8'h7E, 1'b0, 3'd2, 32'h0000_5E7D},
      '{8'h7D, 1'b0, 3'd2, 32'h0000_5D7D},
      '{8'h7C, 1'b0, 3'd0, 32'h0},
      '{8'h5E, 1'b0, 3'd0, 32'h0},
      '{8'h5D, 1'b0, 3'd0, 32'h0},
      '{8'h20, 1'b1, 3'd0, 32'h0},
      '{8'h7E, 1'b1, 3'd0, 32'h0},
      '{8'hFF, 1'b1, 3'd0, 32'h0},
      '{8'h00, 1'b1, 3'd0, 32'h0},
      '{8'h31, 1'b0, 3'd0, 32'h0},
      '{8'h32, 1'b0, 3'd0, 32'h0},
      '{8'h33, 1'b0, 3'd0, 32'h0},
      '{8'h34, 1'b0, 3'd0, 32'h0},
      '{8'h35, 1'b0, 3'd0, 32'h0},
      '{8'h36, 1'b0, 3'd0, 32'h0},
      '{8'h37, 1'b0, 3'd0, 32'h0},
      '{8'h38, 1'b0, 3'd0, 32'h0},
      '{8'h39, 1'b1, 3'd4, 32'h7E90_6E39}
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) send_beat(plan[i].data, plan[i].fin, plan[i].n_lit, plan[i].lit);

    // Hold the receiver off while frames keep coming
    hold_req = 1'b1;
    frame_no = 0;
    while (sent_items < NUM_ITEMS) begin
      roll = $urandom_range(0, 9);
      if (roll < 6) begin
        frame_len = $urandom_range(1, 6);
      end else if (roll < 9) begin
        frame_len = $urandom_range(7, 16);
      end else begin
        frame_len = $urandom_range(17, 40);
      end
      steady_tx = ($urandom_range(0, 4) == 0);
      seek      = ($urandom_range(0, 2) == 0);
      for (int i = 0; i < frame_len; i++) begin
        if ($urandom_range(0, 7) == 0) begin
          d = $urandom_range(0, 1) ? FLAG_BYTE : ESC_BYTE;
        end else begin
          d = 8'($urandom_range(0, 255));
        end
        // Pick a final byte whose CRC trailer needs an escape, if one exists
        if (seek && i == frame_len - 1) begin
          found = 1'b0;
          base  = 8'($urandom_range(0, 255));
          for (int k = 0; k < 256; k++) begin
            cand = base + k[7:0];
            t    = crc16_step(frame_crc, cand) ^ CRC_INIT;
            if (!found && (t[7:0] == FLAG_BYTE || t[7:0] == ESC_BYTE ||
                           t[15:8] == FLAG_BYTE || t[15:8] == ESC_BYTE)) begin
              d     = cand;
              found = 1'b1;
            end
          end
        end
        send_beat(d, (i == frame_len - 1), 3'd0, 32'h0);
      end
      frame_no++;
      // After the fifteenth frame, pause the sender until every expected beat is out
      if (frame_no == 15) begin
        in_bus.valid <= 1'b0;
        while (encoded_q.size() != 0) @(posedge clk);
      end
    end
    steady_tx = 1'b0;

    in_bus.valid <= 1'b0;
    while (encoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
